// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the servo driver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define PTSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true out of reset.
`define PTSS_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== hdl/ptss_pkg.sv =====
// Shared types and fixed constants of the pan/tilt servo driver.
package ptss_pkg;

  localparam int SLEW_W   = 10;
  localparam int US_W     = 12;
  localparam int GOAL_W   = 16;
  localparam int MS_W     = 16;
  localparam int IDX_W    = 3;
  localparam int CFG_W    = 12;

  localparam int MS_PER_S = 1000;
  localparam int DEG_FULL = 180;
  localparam int DEG_MID  = 90;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [IDX_W-1:0] REG_SLEW      = 3'd0;
  localparam logic [IDX_W-1:0] REG_PAN_MIN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_PAN_MAX   = 3'd2;
  localparam logic [IDX_W-1:0] REG_PAN_INV   = 3'd3;
  localparam logic [IDX_W-1:0] REG_TILT_MIN  = 3'd4;
  localparam logic [IDX_W-1:0] REG_TILT_MAX  = 3'd5;
  localparam logic [IDX_W-1:0] REG_TILT_INV  = 3'd6;

  localparam logic [SLEW_W-1:0] RST_SLEW   = 10'd180;
  localparam logic [US_W-1:0]   RST_MIN_US = 12'd500;
  localparam logic [US_W-1:0]   RST_MAX_US = 12'd2500;

  typedef struct packed {
    logic [US_W-1:0] min_us;
    logic [US_W-1:0] max_us;
    logic            invert;
  } axis_cfg_t;

  function automatic logic [US_W-1:0] span_of(axis_cfg_t c);
    logic [US_W-1:0] s;
    s = (c.max_us > c.min_us) ? (c.max_us - c.min_us) : '0;
    return s;
  endfunction

endpackage

// ===== hdl/ptss_smul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module ptss_smul import ptss_pkg::*; #(
  parameter int A_W = 32,
  parameter int B_W = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  output logic           busy,
  output logic           done,
  output logic [A_W-1:0] prod
);

  localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

  logic [A_W-1:0]   a_r;
  logic [B_W-1:0]   b_r;
  logic [A_W-1:0]   acc_r;
  logic [A_W-1:0]   acc_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  assign acc_nxt = acc_r + (b_r[0] ? a_r : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(B_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      a_r   <= {a_r[A_W-2:0], 1'b0};
      b_r   <= {1'b0, b_r[B_W-1:1]};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== hdl/ptss_sdiv.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module ptss_sdiv import ptss_pkg::*; #(
  parameter int N_W = 32,
  parameter int D_W = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           busy,
  output logic           done,
  output logic [N_W-1:0] quot
);

  localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

  logic [N_W-1:0]   dvd_r;
  logic [D_W-1:0]   dvs_r;
  logic [D_W-1:0]   rem_r;
  logic [D_W-1:0]   rem_nxt;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             fits;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  assign trial   = {rem_r, dvd_r[N_W-1]};
  assign fits    = (trial >= {1'b0, dvs_r});
  assign diff    = trial - {1'b0, dvs_r};
  assign rem_nxt = fits ? diff[D_W-1:0] : trial[D_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[N_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = dvd_r;

endmodule

// ===== hdl/pan_tilt_servo_slew_pwm.sv =====
// Top level of the two-axis slew-limited servo driver with PWM duty output.
//
// Input beats (in_*): tuser is the opcode, 0 sets new targets and 1 is a time
// tick; tdata carries pan_goal, tilt_goal and elapsed_ms. Every input beat
// yields exactly one output beat (out_*) with both current angles, both
// targets and both PWM duties. The user must write registers through cfg_we,
// cfg_addr and cfg_wdata only while no beat is in flight; the block does not enforce this.
// One item at a time runs through a bit-serial multiplier and a bit-serial
// divider, one bit per cycle; the divider is 32 bits wide at the defaults and
// the multiplier operand 16 bits. A tick computes the slew step from the rate
// and elapsed_ms, moves both angles, then for pan and then tilt scales the
// angle into a pulse width and divides it into a PWM duty; a set-target beat
// skips the step and move. in_tready rises together with out_tvalid.
// The output register holds a finished beat while the next item is taken;
// a stalled receiver only holds the block once a second result is ready.
// Reset restores default registers, pan at 90 degrees and tilt at 0, with
// targets equal to the angles, and empties the output.
`include "assert_macros.svh"

module pan_tilt_servo_slew_pwm import ptss_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 6,
  parameter int DUTY_BITS       = 16,
  parameter int PERIOD_US       = 20000,
  localparam int FULL     = DEG_FULL << ANGLE_FRAC_BITS,
  localparam int AW       = $clog2(FULL + 1),
  localparam int IN_BITS  = 2 * GOAL_W + MS_W,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 4 * AW + 2 * DUTY_BITS,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // pan_goal, tilt_goal, elapsed_ms
  input  logic [IN_W-1:0]  in_tdata,
  // opcode
  input  logic             in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // pan_angle, tilt_angle, pan_target, tilt_target, pan_duty, tilt_duty
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int MID = DEG_MID << ANGLE_FRAC_BITS;
  localparam int MBW = (MS_W > AW) ? MS_W : AW;
  localparam int P1  = SLEW_W + MS_W + ANGLE_FRAC_BITS;
  localparam int P2  = US_W + AW;
  localparam int P3  = US_W + DUTY_BITS;
  localparam int P12 = (P1 > P2) ? P1 : P2;
  localparam int DVW = (P12 > P3) ? P12 : P3;
  localparam int D1  = $clog2(MS_PER_S + 1);
  localparam int D3  = $clog2(PERIOD_US + 1);
  localparam int D12 = (D1 > AW) ? D1 : AW;
  localparam int DSW = (D12 > D3) ? D12 : D3;
  localparam logic [DVW-1:0] DUTY_TOP = DVW'((64'd1 << DUTY_BITS) - 64'd1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_STEP_MUL = 3'd1;
  localparam logic [2:0] S_STEP_DIV = 3'd2;
  localparam logic [2:0] S_SLEW     = 3'd3;
  localparam logic [2:0] S_AX_MUL   = 3'd4;
  localparam logic [2:0] S_AX_DIV   = 3'd5;
  localparam logic [2:0] S_AX_DUTY  = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]           state_r, state_nxt;
  logic                 ax_r, ax_nxt;
  logic [SLEW_W-1:0]    slew_r;
  axis_cfg_t            pan_cfg_r, tilt_cfg_r;
  logic [AW-1:0]        pan_now_r, tilt_now_r;
  logic [AW-1:0]        pan_tgt_r, tilt_tgt_r;
  logic [AW-1:0]        step_r;
  logic [DUTY_BITS-1:0] pan_duty_r, tilt_duty_r;
  logic                 out_tvalid_r;
  logic [OUT_W-1:0]     out_tdata_r;

  logic                 in_acc;
  logic                 in_op;
  logic [GOAL_W-1:0]    in_pan_goal, in_tilt_goal;
  logic [MS_W-1:0]      in_ms;

  logic                 mul_start, mul_tick, mul_ax, mul_busy, mul_done;
  logic [DVW-1:0]       mul_a, mul_prod;
  logic [MBW-1:0]       mul_b;
  logic                 div_start, div_busy, div_done;
  logic [DVW-1:0]       div_dvd, div_q;
  logic [DSW-1:0]       div_dvs;

  axis_cfg_t            sel_cfg, cur_cfg;
  logic [AW-1:0]        sel_ang, sel_mir;
  logic [AW-1:0]        pan_slew_c, tilt_slew_c, pan_src;
  logic [US_W-1:0]      us_c;
  logic [AW-1:0]        step_c;
  logic [DUTY_BITS-1:0] duty_c;

  function automatic logic [AW-1:0] clamp_goal(logic [GOAL_W-1:0] g);
    logic [AW-1:0] r;
    if (g[GOAL_W-1]) begin
      r = '0;
    end else if (32'(g) > 32'(FULL)) begin
      r = AW'(FULL);
    end else begin
      r = AW'(g);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] slew_to(logic [AW-1:0] now, logic [AW-1:0] goal,
                                            logic [AW-1:0] step);
    logic [AW-1:0] r;
    if (goal > now) begin
      r = ((goal - now) > step) ? (now + step) : goal;
    end else begin
      r = ((now - goal) > step) ? (now - step) : goal;
    end
    return r;
  endfunction

  assign in_tready    = (state_r == S_IDLE);
  assign in_acc       = in_tvalid && in_tready;
  assign in_op        = in_tuser;
  assign in_pan_goal  = in_tdata[GOAL_W-1:0];
  assign in_tilt_goal = in_tdata[2*GOAL_W-1:GOAL_W];
  assign in_ms        = in_tdata[2*GOAL_W+MS_W-1:2*GOAL_W];

  assign pan_slew_c  = slew_to(pan_now_r, pan_tgt_r, step_r);
  assign tilt_slew_c = slew_to(tilt_now_r, tilt_tgt_r, step_r);
  assign pan_src     = (state_r == S_SLEW) ? pan_slew_c : pan_now_r;

  assign sel_cfg = mul_ax ? tilt_cfg_r : pan_cfg_r;
  assign sel_ang = mul_ax ? tilt_now_r : pan_src;
  assign sel_mir = sel_cfg.invert ? (AW'(FULL) - sel_ang) : sel_ang;
  assign mul_a   = mul_tick ? DVW'(slew_r) : DVW'(span_of(sel_cfg));
  assign mul_b   = mul_tick ? MBW'(in_ms) : MBW'(sel_mir);

  assign cur_cfg = ax_r ? tilt_cfg_r : pan_cfg_r;
  assign us_c    = cur_cfg.min_us + div_q[US_W-1:0];
  assign step_c  = (div_q > DVW'(FULL)) ? AW'(FULL) : div_q[AW-1:0];
  assign duty_c  = (div_q > DUTY_TOP) ? DUTY_TOP[DUTY_BITS-1:0] : div_q[DUTY_BITS-1:0];

  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    mul_start = 1'b0;
    mul_tick  = 1'b0;
    mul_ax    = 1'b0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mul_start = 1'b1;
          if (in_op == OP_TICK) begin
            mul_tick  = 1'b1;
            state_nxt = S_STEP_MUL;
          end else begin
            ax_nxt    = 1'b0;
            state_nxt = S_AX_MUL;
          end
        end
      end
      S_STEP_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_dvd   = mul_prod << ANGLE_FRAC_BITS;
          div_dvs   = DSW'(MS_PER_S);
          state_nxt = S_STEP_DIV;
        end
      end
      S_STEP_DIV: begin
        if (div_done) begin
          state_nxt = S_SLEW;
        end
      end
      S_SLEW: begin
        mul_start = 1'b1;
        ax_nxt    = 1'b0;
        state_nxt = S_AX_MUL;
      end
      S_AX_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_dvd   = mul_prod;
          div_dvs   = DSW'(FULL);
          state_nxt = S_AX_DIV;
        end
      end
      S_AX_DIV: begin
        if (div_done) begin
          div_start = 1'b1;
          div_dvd   = DVW'(us_c) << DUTY_BITS;
          div_dvs   = DSW'(PERIOD_US);
          state_nxt = S_AX_DUTY;
        end
      end
      S_AX_DUTY: begin
        if (div_done) begin
          if (!ax_r) begin
            mul_start = 1'b1;
            mul_ax    = 1'b1;
            ax_nxt    = 1'b1;
            state_nxt = S_AX_MUL;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ax_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
      slew_r       <= RST_SLEW;
      pan_cfg_r    <= '{min_us: RST_MIN_US, max_us: RST_MAX_US, invert: 1'b0};
      tilt_cfg_r   <= '{min_us: RST_MIN_US, max_us: RST_MAX_US, invert: 1'b0};
      pan_now_r    <= AW'(MID);
      tilt_now_r   <= '0;
      pan_tgt_r    <= AW'(MID);
      tilt_tgt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ax_r    <= ax_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_SLEW:     slew_r            <= cfg_wdata[SLEW_W-1:0];
          REG_PAN_MIN:  pan_cfg_r.min_us  <= cfg_wdata[US_W-1:0];
          REG_PAN_MAX:  pan_cfg_r.max_us  <= cfg_wdata[US_W-1:0];
          REG_PAN_INV:  pan_cfg_r.invert  <= cfg_wdata[0];
          REG_TILT_MIN: tilt_cfg_r.min_us <= cfg_wdata[US_W-1:0];
          REG_TILT_MAX: tilt_cfg_r.max_us <= cfg_wdata[US_W-1:0];
          REG_TILT_INV: tilt_cfg_r.invert <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_acc && (in_op == OP_SET)) begin
        pan_tgt_r  <= clamp_goal(in_pan_goal);
        tilt_tgt_r <= clamp_goal(in_tilt_goal);
      end
      if (state_r == S_SLEW) begin
        pan_now_r  <= pan_slew_c;
        tilt_now_r <= tilt_slew_c;
      end
      if ((state_r == S_DONE) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_STEP_DIV) && div_done) begin
      step_r <= step_c;
    end
    if ((state_r == S_AX_DUTY) && div_done) begin
      if (!ax_r) begin
        pan_duty_r <= duty_c;
      end else begin
        tilt_duty_r <= duty_c;
      end
    end
    if ((state_r == S_DONE) && (!out_tvalid_r || out_tready)) begin
      out_tdata_r <= OUT_W'({tilt_duty_r, pan_duty_r, tilt_tgt_r, pan_tgt_r,
                             tilt_now_r, pan_now_r});
    end
  end

  ptss_smul #(
    .A_W (DVW),
    .B_W (MBW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ptss_sdiv #(
    .N_W (DVW),
    .D_W (DSW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `PTSS_NEVER(a_units_overlap, mul_busy && div_busy, "multiplier and divider busy together")
  `PTSS_ASSERT(a_one_in_flight, (in_tvalid && in_tready) |=> !in_tready, "second item taken in flight")
  `PTSS_ASSERT(a_angle_range, (pan_now_r <= AW'(FULL)) && (tilt_now_r <= AW'(FULL)), "angle beyond full scale")
  `PTSS_ASSERT(a_result_from_done, $rose(out_tvalid_r) |-> $past(state_r == S_DONE), "result without finished item")

endmodule

// ===== tb/tb_pan_tilt_servo_slew_pwm.sv =====
// Self-checking testbench for the pan/tilt slew-limited servo PWM driver.
`timescale 1ns / 1ps

module tb_pan_tilt_servo_slew_pwm;
  import ptss_pkg::*;

  localparam int FRAC_BITS  = 6;
  localparam int DUTY_W     = 16;
  localparam int PERIOD     = 20000;
  localparam int FULL_SCALE = DEG_FULL << FRAC_BITS;
  localparam int AW         = 14;
  localparam int IN_W       = 48;
  localparam int OUT_W      = 88;
  localparam longint unsigned DUTY_TOP = (64'd1 << DUTY_W) - 1;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE     = 12;
  localparam int TAIL       = 250;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 235;
  localparam int HOLD_CYCLES = 2500;
  localparam longint LIMIT  = 3000000;

  typedef struct {
    logic                     op;
    logic signed [GOAL_W-1:0] pan_goal;
    logic signed [GOAL_W-1:0] tilt_goal;
    logic [MS_W-1:0]          elapsed_ms;
  } servo_cmd_t;

  typedef struct {
    logic [AW-1:0]     pan_angle;
    logic [AW-1:0]     tilt_angle;
    logic [AW-1:0]     pan_target;
    logic [AW-1:0]     tilt_target;
    logic [DUTY_W-1:0] pan_duty;
    logic [DUTY_W-1:0] tilt_duty;
  } servo_report_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  pan_tilt_servo_slew_pwm DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Servo state and register copies
  logic [SLEW_W-1:0] rate_dps;
  axis_cfg_t         pan_cfg, tilt_cfg;
  logic [AW-1:0]     pan_pos, tilt_pos, pan_aim, tilt_aim;

  servo_cmd_t    cmd_backlog[$];
  servo_report_t reports_due[$];
  servo_cmd_t    cur_cmd;

  int     errors = 0;
  int     n_sets = 0;
  int     n_ticks = 0;
  int     n_beats = 0;
  int     n_settings = 1;
  longint cycle_count = 0;
  int     tx_gap = 0, tx_calm = 0;
  int     rx_stall = 0, rx_calm = 0;
  int     hold_left = 0;
  bit     held_off = 1'b0;

  function automatic logic [AW-1:0] clamp_goal(logic signed [GOAL_W-1:0] g);
    int v;
    v = int'(g);
    if (v < 0) v = 0;
    else if (v > FULL_SCALE) v = FULL_SCALE;
    return v[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] slew_toward(logic [AW-1:0] now, logic [AW-1:0] goal,
                                                longint unsigned step);
    longint unsigned n, g;
    n = 64'(now);
    g = 64'(goal);
    if (g > n) n = (g - n > step) ? n + step : g;
    else n = (n - g > step) ? n - step : g;
    return n[AW-1:0];
  endfunction

  function automatic logic [DUTY_W-1:0] pwm_compare(logic [AW-1:0] angle, axis_cfg_t c);
    longint unsigned a, span, us, duty;
    a = 64'(angle);
    if (a > FULL_SCALE) a = FULL_SCALE;
    if (c.invert) a = FULL_SCALE - a;
    if (c.max_us > c.min_us) span = 64'(c.max_us) - 64'(c.min_us);
    else span = 0;
    us = 64'(c.min_us) + (span * a) / FULL_SCALE;
    duty = (us << DUTY_W) / PERIOD;
    if (duty > DUTY_TOP) duty = DUTY_TOP;
    return duty[DUTY_W-1:0];
  endfunction

  function automatic servo_report_t servo_advance(servo_cmd_t cmd);
    servo_report_t   r;
    longint unsigned rate64, step;
    if (cmd.op == OP_SET) begin
      pan_aim  = clamp_goal(cmd.pan_goal);
      tilt_aim = clamp_goal(cmd.tilt_goal);
    end else begin
      rate64   = 64'(rate_dps);
      step     = ((rate64 * 64'(cmd.elapsed_ms)) << FRAC_BITS) / MS_PER_S;
      pan_pos  = slew_toward(pan_pos, pan_aim, step);
      tilt_pos = slew_toward(tilt_pos, tilt_aim, step);
    end
    r.pan_angle   = pan_pos;
    r.tilt_angle  = tilt_pos;
    r.pan_target  = pan_aim;
    r.tilt_target = tilt_aim;
    r.pan_duty    = pwm_compare(pan_pos, pan_cfg);
    r.tilt_duty   = pwm_compare(tilt_pos, tilt_cfg);
    return r;
  endfunction

  function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    case (idx)
      REG_SLEW:     rate_dps = v[SLEW_W-1:0];
      REG_PAN_MIN:  pan_cfg.min_us = v[US_W-1:0];
      REG_PAN_MAX:  pan_cfg.max_us = v[US_W-1:0];
      REG_PAN_INV:  pan_cfg.invert = v[0];
      REG_TILT_MIN: tilt_cfg.min_us = v[US_W-1:0];
      REG_TILT_MAX: tilt_cfg.max_us = v[US_W-1:0];
      REG_TILT_INV: tilt_cfg.invert = v[0];
      default: ;
    endcase
  endfunction

  function automatic int pick_pause(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      calm = int'($urandom_range(8, 40));
      return 0;
    end
    return int'($urandom_range(0, 13));
  endfunction

  function automatic servo_cmd_t set_cmd(int pan_goal, int tilt_goal);
    servo_cmd_t c;
    c.op         = OP_SET;
    c.pan_goal   = GOAL_W'(pan_goal);
    c.tilt_goal  = GOAL_W'(tilt_goal);
    c.elapsed_ms = MS_W'($urandom_range(0, 65535));
    return c;
  endfunction

  function automatic servo_cmd_t tick_cmd(int ms);
    servo_cmd_t c;
    c.op         = OP_TICK;
    c.pan_goal   = GOAL_W'($urandom_range(0, 65535));
    c.tilt_goal  = GOAL_W'($urandom_range(0, 65535));
    c.elapsed_ms = MS_W'(ms);
    return c;
  endfunction

  function automatic int random_goal();
    case ($urandom_range(0, 9))
      0:       return int'($signed(16'($urandom_range(0, 65535))));
      1:       return $urandom_range(0, 1) ? FULL_SCALE : 0;
      default: return int'($urandom_range(0, FULL_SCALE));
    endcase
  endfunction

  function automatic servo_cmd_t random_cmd();
    int ms;
    case ($urandom_range(0, 9))
      0:       ms = int'($urandom_range(0, 65535));
      1, 2:    ms = int'($urandom_range(0, 2000));
      default: ms = int'($urandom_range(0, 120));
    endcase
    if ($urandom_range(0, 3) == 0) return set_cmd(random_goal(), random_goal());
    return tick_cmd(ms);
  endfunction

  function automatic axis_cfg_t random_axis();
    axis_cfg_t c;
    case ($urandom_range(0, 7))
      0: begin
        c.min_us = US_W'($urandom_range(1500, 4095));
        c.max_us = US_W'($urandom_range(0, 1499));
      end
      1: begin
        c.min_us = 12'd0;
        c.max_us = 12'hFFF;
      end
      2: begin
        c.min_us = US_W'($urandom_range(0, 4095));
        c.max_us = c.min_us;
      end
      default: begin
        c.min_us = US_W'($urandom_range(300, 900));
        c.max_us = US_W'($urandom_range(2000, 2800));
      end
    endcase
    c.invert = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    apply_reg(idx, v);
  endtask

  task automatic finish_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || in_tvalid || reports_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic randomize_settings();
    axis_cfg_t p, t;
    int        r;
    p = random_axis();
    t = random_axis();
    case ($urandom_range(0, 9))
      0:       r = 0;
      1:       r = 1023;
      default: r = int'($urandom_range(1, 1023));
    endcase
    // upper bits beyond the slew width must be dropped
    write_reg(REG_SLEW, {2'($urandom_range(0, 3)), 10'(r)});
    write_reg(REG_PAN_MIN, p.min_us);
    write_reg(REG_PAN_MAX, p.max_us);
    write_reg(REG_PAN_INV, {11'($urandom_range(0, 2047)), p.invert});
    write_reg(REG_TILT_MIN, t.min_us);
    write_reg(REG_TILT_MAX, t.max_us);
    write_reg(REG_TILT_INV, {11'($urandom_range(0, 2047)), t.invert});
    if ($urandom_range(0, 1)) write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 4095)));
    finish_writes();
  endtask

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        reports_due.push_back(servo_advance(cur_cmd));
        if (cur_cmd.op == OP_SET) n_sets++;
        else n_ticks++;
        tx_gap = pick_pause(tx_calm);
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          cur_cmd = cmd_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cur_cmd.op;
          in_tdata  <= {cur_cmd.elapsed_ms, cur_cmd.tilt_goal, cur_cmd.pan_goal};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Result monitor
  always @(posedge clk) begin
    servo_report_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_beats++;
        if (reports_due.size() == 0) begin
          $error("unexpected result beat: %h", out_tdata);
          errors++;
        end else begin
          want = reports_due.pop_front();
          check_field("pan_angle", want.pan_angle, out_tdata[0 +: AW]);
          check_field("tilt_angle", want.tilt_angle, out_tdata[AW +: AW]);
          check_field("pan_target", want.pan_target, out_tdata[2*AW +: AW]);
          check_field("tilt_target", want.tilt_target, out_tdata[3*AW +: AW]);
          check_field("pan_duty", want.pan_duty, out_tdata[4*AW +: DUTY_W]);
          check_field("tilt_duty", want.tilt_duty, out_tdata[4*AW+DUTY_W +: DUTY_W]);
        end
        rx_stall = pick_pause(rx_calm);
        // hold off once while the sender still has plenty queued
        if (!held_off && n_beats >= 50 && cmd_backlog.size() > 20) begin
          held_off  = 1'b1;
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               reports_due.size());
      $display("pan_tilt_servo_slew_pwm test failed");
      $finish;
    end
  end

  initial begin
    rate_dps = RST_SLEW;
    pan_cfg  = '{min_us: RST_MIN_US, max_us: RST_MAX_US, invert: 1'b0};
    tilt_cfg = '{min_us: RST_MIN_US, max_us: RST_MAX_US, invert: 1'b0};
    pan_pos  = AW'(DEG_MID << FRAC_BITS);
    pan_aim  = AW'(DEG_MID << FRAC_BITS);
    tilt_pos = '0;
    tilt_aim = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: clamping, zero and huge elapsed time, ignored fields
    cmd_backlog.push_back(tick_cmd(0));
    cmd_backlog.push_back(set_cmd(-32768, 32767));
    cmd_backlog.push_back(tick_cmd(1));
    cmd_backlog.push_back(tick_cmd(1000));
    cmd_backlog.push_back(set_cmd(FULL_SCALE + 1, -1));
    cmd_backlog.push_back(tick_cmd(65535));
    cmd_backlog.push_back(set_cmd(0, FULL_SCALE));
    cmd_backlog.push_back(set_cmd(FULL_SCALE, 0));
    cmd_backlog.push_back(tick_cmd(500));
    cmd_backlog.push_back(set_cmd(FULL_SCALE / 2, FULL_SCALE / 2));
    cmd_backlog.push_back(tick_cmd(10));
    cmd_backlog.push_back(tick_cmd(3));
    cmd_backlog.push_back(set_cmd(FULL_SCALE - 1, 1));
    cmd_backlog.push_back(tick_cmd(1000));
    wait_idle();

    // zero slew, inverted spans, mirrored axes, write to an unused index
    write_reg(REG_SLEW, 12'hC00);
    write_reg(REG_PAN_MIN, 12'hFFF);
    write_reg(REG_PAN_MAX, 12'h000);
    write_reg(REG_PAN_INV, 12'h001);
    write_reg(REG_TILT_MIN, 12'h000);
    write_reg(REG_TILT_MAX, 12'hFFF);
    write_reg(REG_TILT_INV, 12'hFFF);
    write_reg(REG_UNUSED, 12'hFFF);
    finish_writes();
    cmd_backlog.push_back(tick_cmd(65535));
    cmd_backlog.push_back(set_cmd(0, FULL_SCALE));
    cmd_backlog.push_back(tick_cmd(65535));
    wait_idle();

    // fastest slew, full pulse range
    write_reg(REG_SLEW, 12'hFFF);
    write_reg(REG_PAN_MIN, 12'h000);
    write_reg(REG_PAN_MAX, 12'hFFF);
    write_reg(REG_PAN_INV, 12'h000);
    write_reg(REG_TILT_INV, 12'h000);
    finish_writes();
    cmd_backlog.push_back(tick_cmd(1));
    cmd_backlog.push_back(tick_cmd(65535));
    cmd_backlog.push_back(set_cmd(FULL_SCALE, 0));
    cmd_backlog.push_back(tick_cmd(65535));
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      randomize_settings();
      for (int i = 0; i < PHASE_ITEMS; i++) cmd_backlog.push_back(random_cmd());
      wait_idle();
    end

    repeat (TAIL) @(posedge clk);
    if (reports_due.size() != 0) begin
      $error("%0d expected results never arrived", reports_due.size());
      errors++;
    end
    $display("Ran %0d target updates and %0d ticks under %0d register settings.",
             n_sets, n_ticks, n_settings);
    $display("Checked %0d result beats, including one long output hold-off.", n_beats);
    if (errors == 0) begin
      $display("pan_tilt_servo_slew_pwm test passed");
    end else begin
      $display("pan_tilt_servo_slew_pwm test failed");
    end
    $finish;
  end

endmodule
